/* hdl/lca_pkg.sv */
`timescale 1ns / 1ps

package lca_pkg;

   // grid store geometry
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 128;

   // row address and column index widths
   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int COL_AW = $clog2(MAX_COLUMNS);

   // widths that can hold a count of rows or columns, at least as wide as the registers
   localparam int ROWS_W = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
   localparam int COLS_W = ($clog2(MAX_COLUMNS + 1) > 8) ? $clog2(MAX_COLUMNS + 1) : 8;

   // item kinds
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_TOGGLE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS     = 2'd3;

   // register reset values
   localparam logic [15:0] TICK_INTERVAL_RESET = 16'd1000;
   localparam logic [7:0]  GRID_COLUMNS_RESET  = 8'd80;
   localparam logic [6:0]  GRID_ROWS_RESET     = 7'd45;

   typedef logic [MAX_COLUMNS-1:0] row_type;

   // one new row of the b3/s23 rule from the old rows above, here and below
   function automatic row_type life_next_row(input row_type above, input row_type here,
                                             input row_type below, input row_type col_mask);
      row_type    nxt;
      logic [3:0] n;
      logic       l_a, l_h, l_b, r_a, r_h, r_b;
      nxt = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         l_a = (c > 0) ? above[(c > 0) ? c - 1 : 0] : 1'b0;
         l_h = (c > 0) ? here[(c > 0) ? c - 1 : 0]  : 1'b0;
         l_b = (c > 0) ? below[(c > 0) ? c - 1 : 0] : 1'b0;
         r_a = (c < MAX_COLUMNS - 1) ? above[(c < MAX_COLUMNS - 1) ? c + 1 : c] : 1'b0;
         r_h = (c < MAX_COLUMNS - 1) ? here[(c < MAX_COLUMNS - 1) ? c + 1 : c]  : 1'b0;
         r_b = (c < MAX_COLUMNS - 1) ? below[(c < MAX_COLUMNS - 1) ? c + 1 : c] : 1'b0;
         n = 4'(l_a) + 4'(above[c]) + 4'(r_a) + 4'(l_h) + 4'(r_h)
           + 4'(l_b) + 4'(below[c]) + 4'(r_b);
         nxt[c] = col_mask[c] & ((n == 4'd3) | (here[c] & (n == 4'd2)));
      end
      return nxt;
   endfunction

endpackage

/* hdl/life_cellular_automaton_core.sv */
`timescale 1ns / 1ps
// steps: toggle or read fetches the row, then writes or reports the cell; a tick with no generation
// (or no rows in use) goes to the result; clear writes every grid row in turn
// flow: one item at a time, the next taken once the result is registered; a generation reads
// rows 0 and 1, then per row writes the new row and shifts the row window
// reset: synchronous, sets control and the registers to their reset values, then a clearing pass
// writes every grid row to zero while no item is taken; a geometry write starts the same pass
module life_cellular_automaton_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_row [5:0], cell_column [12:6], zero fill
   input  logic [1:0]  req_tuser,   // mode [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cell_alive [0], generation [32:1], zero fill
   output logic        rsp_tuser,   // advanced [0]
   // register write port
   input  logic        csr_we,
   input  logic [lca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int ROW_AW = lca_pkg::ROW_AW;
   localparam int COL_AW = lca_pkg::COL_AW;
   localparam int ROWS_W = lca_pkg::ROWS_W;
   localparam int COLS_W = lca_pkg::COLS_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_CELL  = 3'd2;
   localparam logic [2:0] S_G1    = 3'd3;
   localparam logic [2:0] S_G2    = 3'd4;
   localparam logic [2:0] S_GW    = 3'd5;
   localparam logic [2:0] S_GS    = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // grid memory, one row of cells per entry
   lca_pkg::row_type grid_ram_ff [lca_pkg::MAX_ROWS];
   lca_pkg::row_type rd_data_ff;
   logic             rd_en;
   logic [ROW_AW-1:0] rd_addr;
   logic             wr_en;
   logic [ROW_AW-1:0] wr_addr;
   lca_pkg::row_type wr_data;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [ROW_AW-1:0] clr_row_ff, clr_row_in;
   logic              clr_rsp_ff, clr_rsp_in;   // clear pass owes a result item
   logic [ROWS_W-1:0] gen_row_ff, gen_row_in;

   // row window for the generation sweep
   lca_pkg::row_type above_ff, above_in;
   lca_pkg::row_type here_ff, here_in;
   lca_pkg::row_type below_ff, below_in;

   // captured item
   logic [1:0]        mode_ff, mode_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [COL_AW-1:0] col_ff, col_in;
   logic              inside_ff, inside_in;

   // pending result
   logic              alive_ff, alive_in;
   logic              adv_ff, adv_in;

   // architectural state and registers
   logic [31:0]       gen_count_ff, gen_count_in;
   logic [15:0]       elapsed_ff, elapsed_in;
   logic              run_en_ff, run_en_in;
   logic [15:0]       interval_ff, interval_in;
   logic [7:0]        cols_ff, cols_in;
   logic [6:0]        rows_ff, rows_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_alive_ff, rsp_alive_in;
   logic [31:0]       rsp_gen_ff, rsp_gen_in;
   logic              rsp_adv_ff, rsp_adv_in;

   // helpers
   logic [COLS_W-1:0] used_cols;
   logic [ROWS_W-1:0] used_rows;
   lca_pkg::row_type  col_mask;
   lca_pkg::row_type  new_row;
   logic              req_fire;
   logic [1:0]        req_mode;
   logic [5:0]        req_row;
   logic [6:0]        req_col;
   logic              req_inside;
   logic [15:0]       elapsed_inc;
   logic [ROWS_W:0]   row_plus2;
   logic              row_plus2_ok;
   logic              cell_bit;
   logic              geom_write;

   // memory, written and read in clocked blocks
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= grid_ram_ff[rd_addr];
      end
   end

   // oversized geometry acts as the store size
   assign used_cols = (COLS_W'(cols_ff) > COLS_W'(lca_pkg::MAX_COLUMNS))
                      ? COLS_W'(lca_pkg::MAX_COLUMNS) : COLS_W'(cols_ff);
   assign used_rows = (ROWS_W'(rows_ff) > ROWS_W'(lca_pkg::MAX_ROWS))
                      ? ROWS_W'(lca_pkg::MAX_ROWS) : ROWS_W'(rows_ff);

   always_comb begin
      for (int c = 0; c < lca_pkg::MAX_COLUMNS; c++) begin
         col_mask[c] = (COLS_W'(c) < used_cols);
      end
   end

   // cells outside the area in use are always dead, so rows past the edge read as zero
   assign new_row = lca_pkg::life_next_row(above_ff, here_ff, below_ff, col_mask);

   assign req_fire   = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[12:6];
   assign req_inside = (ROWS_W'(req_row) < used_rows) && (COLS_W'(req_col) < used_cols);

   // millisecond count saturates
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   assign row_plus2    = (ROWS_W + 1)'(gen_row_ff) + (ROWS_W + 1)'(2);
   assign row_plus2_ok = (row_plus2 < (ROWS_W + 1)'(lca_pkg::MAX_ROWS));
   assign cell_bit     = rd_data_ff[col_ff];

   assign geom_write = csr_we && ((csr_index == lca_pkg::CSR_GRID_COLUMNS) ||
                                  (csr_index == lca_pkg::CSR_GRID_ROWS));

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      clr_rsp_in   = clr_rsp_ff;
      gen_row_in   = gen_row_ff;
      above_in     = above_ff;
      here_in      = here_ff;
      below_in     = below_ff;
      mode_in      = mode_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      inside_in    = inside_ff;
      alive_in     = alive_ff;
      adv_in       = adv_ff;
      gen_count_in = gen_count_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_alive_in = rsp_alive_ff;
      rsp_gen_in   = rsp_gen_ff;
      rsp_adv_in   = rsp_adv_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in   = req_mode;
               row_in    = ROW_AW'(req_row);
               col_in    = COL_AW'(req_col);
               inside_in = req_inside;
               alive_in  = 1'b0;
               adv_in    = 1'b0;
               unique case (req_mode)
                  lca_pkg::MODE_TICK: begin
                     if (run_en_ff && (elapsed_inc >= interval_ff)) begin
                        elapsed_in = '0;
                        gen_row_in = '0;
                        if (used_rows == '0) begin
                           // nothing in use: only the count moves
                           gen_count_in = gen_count_ff + 32'd1;
                           adv_in       = 1'b1;
                           state_in     = S_DONE;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = '0;
                           state_in = S_G1;
                        end
                     end else begin
                        elapsed_in = elapsed_inc;
                        state_in   = S_DONE;
                     end
                  end
                  lca_pkg::MODE_TOGGLE,
                  lca_pkg::MODE_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ROW_AW'(req_row);
                     state_in = S_CELL;
                  end
                  lca_pkg::MODE_CLEAR: begin
                     gen_count_in = '0;
                     clr_row_in   = '0;
                     clr_rsp_in   = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_row_ff;
            clr_row_in = clr_row_ff + ROW_AW'(1);
            if (clr_row_ff == ROW_AW'(lca_pkg::MAX_ROWS - 1)) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_CELL: begin
            if (inside_ff) begin
               if (mode_ff == lca_pkg::MODE_TOGGLE) begin
                  wr_en          = 1'b1;
                  wr_addr        = row_ff;
                  wr_data        = rd_data_ff;
                  wr_data[col_ff] = ~cell_bit;
                  alive_in       = ~cell_bit;
               end else begin
                  alive_in = cell_bit;
               end
            end
            state_in = S_DONE;
         end
         S_G1: begin
            // row 0 arrives, fetch row 1
            above_in = '0;
            here_in  = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = ROW_AW'(1);
            state_in = S_G2;
         end
         S_G2: begin
            below_in = rd_data_ff;
            state_in = S_GW;
         end
         S_GW: begin
            // write the new row and fetch the one two below, which is still old
            wr_en   = 1'b1;
            wr_addr = ROW_AW'(gen_row_ff);
            wr_data = new_row;
            if (row_plus2_ok) begin
               rd_en   = 1'b1;
               rd_addr = ROW_AW'(row_plus2);
            end
            state_in = S_GS;
         end
         S_GS: begin
            above_in   = here_ff;
            here_in    = below_ff;
            below_in   = row_plus2_ok ? rd_data_ff : '0;
            gen_row_in = gen_row_ff + ROWS_W'(1);
            if ((gen_row_ff + ROWS_W'(1)) < used_rows) begin
               state_in = S_GW;
            end else begin
               gen_count_in = gen_count_ff + 32'd1;
               adv_in       = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = alive_ff;
               rsp_gen_in   = gen_count_ff;
               rsp_adv_in   = adv_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // geometry write clears the grid and the count, elapsed time is kept
      if (geom_write) begin
         gen_count_in = '0;
         clr_row_in   = '0;
         state_in     = S_CLEAR;
      end
   end

   // register file
   always_comb begin
      run_en_in   = run_en_ff;
      interval_in = interval_ff;
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            lca_pkg::CSR_RUN_ENABLE:    run_en_in   = csr_wdata[0];
            lca_pkg::CSR_TICK_INTERVAL: interval_in = csr_wdata;
            lca_pkg::CSR_GRID_COLUMNS:  cols_in     = csr_wdata[7:0];
            lca_pkg::CSR_GRID_ROWS:     rows_in     = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_row_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         gen_count_ff <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         run_en_ff    <= 1'b0;
         interval_ff  <= lca_pkg::TICK_INTERVAL_RESET;
         cols_ff      <= lca_pkg::GRID_COLUMNS_RESET;
         rows_ff      <= lca_pkg::GRID_ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         clr_rsp_ff   <= clr_rsp_in;
         gen_count_ff <= gen_count_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         run_en_ff    <= run_en_in;
         interval_ff  <= interval_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      gen_row_ff   <= gen_row_in;
      above_ff     <= above_in;
      here_ff      <= here_in;
      below_ff     <= below_in;
      mode_ff      <= mode_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      inside_ff    <= inside_in;
      alive_ff     <= alive_in;
      adv_ff       <= adv_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_gen_ff   <= rsp_gen_in;
      rsp_adv_ff   <= rsp_adv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_gen_ff, rsp_alive_ff};
   assign rsp_tuser  = rsp_adv_ff;

endmodule

/* hdl/lca_checker.sv */
`timescale 1ns / 1ps
module lca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a result waiting on a stalled sink stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // the clearing pass after reset takes no item
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken during reset clearing pass");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is at work");

   // a generation step never reports a cell
   a_adv_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("advanced result carries a live cell");

endmodule

bind life_cellular_automaton_core lca_checker u_lca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
